// ===== rtl/core/bspd_pkg.sv =====
// Shared types, constants and lookup tables for the stepped PWM dimmer.
// Used by every module under rtl/core; depends on nothing.

package bspd_pkg;

   // Block sizing
   localparam int NUM_BUTTONS = 4;
   localparam int TIME_BITS   = 32;
   localparam int QUEUE_DEPTH = 2;   // power of two so the pointers wrap on their own

   // Field widths
   localparam int DEBOUNCE_BITS = 16;
   localparam int PERIOD_BITS   = 16;
   localparam int STEP_BITS     = 7;
   localparam int LEVEL_BITS    = 7;
   localparam int PERCENT_BITS  = 6;
   localparam int DUTY_BITS     = 8;
   localparam int COMPARE_BITS  = 16;
   localparam int PRODUCT_BITS  = DUTY_BITS + PERIOD_BITS;
   localparam int CSR_DATA_BITS = 16;
   localparam int CSR_INDEX_BITS = 2;

   // Signed width of the level plus all steps of one sample
   localparam int SUM_BITS = $clog2(NUM_BUTTONS * ((1 << STEP_BITS) - 1) + (1 << LEVEL_BITS)) + 2;

   // Level and duty limits
   localparam int LEVEL_MAX = 100;
   localparam int DUTY_FULL = 255;

   // Register indexes of the configuration port
   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_DEBOUNCE_MS = 2'd0,
      CSR_PWM_PERIOD  = 2'd1,
      CSR_SMALL_STEP  = 2'd2,
      CSR_LARGE_STEP  = 2'd3
   } csr_index_type;

   // Back-end sequencer states
   typedef enum logic [1:0] {
      BK_IDLE,
      BK_MUL,
      BK_DIV,
      BK_FIX
   } back_state_type;

   typedef struct packed {
      logic [DEBOUNCE_BITS-1:0] debounce_ms;
      logic [PERIOD_BITS-1:0]   pwm_period;
      logic [STEP_BITS-1:0]     small_step;
      logic [STEP_BITS-1:0]     large_step;
   } cfg_type;

   typedef struct packed {
      logic [TIME_BITS-1:0]   now_ms;
      logic [NUM_BUTTONS-1:0] button_levels;
   } req_type;

   typedef struct packed {
      logic [COMPARE_BITS-1:0] compare_value;
      logic [DUTY_BITS-1:0]    duty;
      logic [LEVEL_BITS-1:0]   level_percent;
      logic [PERCENT_BITS-1:0] output_percent;
      logic [NUM_BUTTONS-1:0]  press_mask;
      logic                    changed;
   } rsp_type;

   // One classified sample handed from front to back
   typedef struct packed {
      logic [LEVEL_BITS-1:0]  level;
      logic [NUM_BUTTONS-1:0] press_mask;
   } entry_type;

   // Level 0..100 to output percent, (48x + 50) / 100 + 2; unused codes hold the top
   localparam logic [PERCENT_BITS-1:0] MAP_TABLE [0:(1<<LEVEL_BITS)-1] = '{
       2,  2,  3,  3,  4,  4,  5,  5,  6,  6,  7,  7,  8,  8,  9,  9, 10, 10, 11, 11,
      12, 12, 13, 13, 14,
      14, 14, 15, 15, 16, 16, 17, 17, 18, 18, 19, 19, 20, 20, 21, 21, 22, 22, 23, 23,
      24, 24, 25, 25, 26,
      26, 26, 27, 27, 28, 28, 29, 29, 30, 30, 31, 31, 32, 32, 33, 33, 34, 34, 35, 35,
      36, 36, 37, 37, 38,
      38, 38, 39, 39, 40, 40, 41, 41, 42, 42, 43, 43, 44, 44, 45, 45, 46, 46, 47, 47,
      48, 48, 49, 49, 50,
      50,
      50, 50, 50, 50, 50, 50, 50, 50, 50, 50, 50, 50, 50, 50, 50, 50, 50, 50, 50, 50,
      50, 50, 50, 50, 50, 50, 50
   };

   // Output percent to duty byte, percent * 255 / 100 truncated
   localparam logic [DUTY_BITS-1:0] DUTY_TABLE [0:(1<<PERCENT_BITS)-1] = '{
        0,   2,   5,   7,  10,  12,  15,  17,  20,  22,  25,  28,  30,  33,  35,  38,
       40,  43,  45,  48,  51,  53,  56,  58,  61,  63,  66,  68,  71,  73,  76,  79,
       81,  84,  86,  89,  91,  94,  96,  99, 102, 104, 107, 109, 112, 114, 117, 119,
      122, 124, 127, 130, 132, 135, 137, 140, 142, 145, 147, 150, 153, 155, 158, 160
   };

endpackage

// ===== rtl/core/bspd_front.sv =====
// Front end of the stepped PWM dimmer: debounces each button, sums the steps
// and clamps the user level. Depends on bspd_pkg.

module bspd_front (
   input  logic                 clock,
   input  logic                 reset,
   input  bspd_pkg::cfg_type    cfg,
   input  logic                 req_valid,
   input  bspd_pkg::req_type    req_payload,
   input  logic                 queue_full,
   output logic                 push,
   output bspd_pkg::entry_type  push_entry
);

   logic [bspd_pkg::NUM_BUTTONS-1:0]  remembered_ff;
   logic [bspd_pkg::NUM_BUTTONS-1:0]  remembered_in;
   logic [bspd_pkg::TIME_BITS-1:0]    last_time_ff [bspd_pkg::NUM_BUTTONS];
   logic [bspd_pkg::TIME_BITS-1:0]    last_time_in [bspd_pkg::NUM_BUTTONS];
   logic [bspd_pkg::LEVEL_BITS-1:0]   level_ff;
   logic [bspd_pkg::LEVEL_BITS-1:0]   level_in;
   logic [bspd_pkg::NUM_BUTTONS-1:0]  press_mask;

   // Take a transaction whenever the queue has room
   assign push = req_valid && !queue_full;

   // Debounce every button and accumulate the steps of its accepted presses
   always_comb begin
      logic signed [bspd_pkg::SUM_BITS-1:0] total;
      logic signed [bspd_pkg::SUM_BITS-1:0] step;
      logic [bspd_pkg::TIME_BITS-1:0]       elapsed;
      logic                                 differs;
      logic                                 accepted;
      total = $signed({{(bspd_pkg::SUM_BITS-bspd_pkg::LEVEL_BITS){1'b0}}, level_ff});
      press_mask = '0;
      for (int i = 0; i < bspd_pkg::NUM_BUTTONS; i++) begin
         differs  = req_payload.button_levels[i] != remembered_ff[i];
         elapsed  = req_payload.now_ms - last_time_ff[i];
         accepted = differs && (elapsed > bspd_pkg::TIME_BITS'(cfg.debounce_ms));
         remembered_in[i] = req_payload.button_levels[i];
         last_time_in[i]  = accepted ? req_payload.now_ms : last_time_ff[i];
         // Buttons with bit 1 of the index set use the large step
         step = $signed({{(bspd_pkg::SUM_BITS-bspd_pkg::STEP_BITS){1'b0}},
                         ((i & 2) != 0) ? cfg.large_step : cfg.small_step});
         if (accepted && !req_payload.button_levels[i]) begin
            press_mask[i] = 1'b1;
            // Odd buttons step down
            if ((i & 1) != 0) begin
               total = total - step;
            end else begin
               total = total + step;
            end
         end
      end
      // Clamp once to the level range
      if (total < 0) begin
         level_in = '0;
      end else if (total > $signed(bspd_pkg::SUM_BITS'(bspd_pkg::LEVEL_MAX))) begin
         level_in = bspd_pkg::LEVEL_BITS'(bspd_pkg::LEVEL_MAX);
      end else begin
         level_in = total[bspd_pkg::LEVEL_BITS-1:0];
      end
   end

   assign push_entry.level      = level_in;
   assign push_entry.press_mask = press_mask;

   // Update the debounce state and the level on each accepted sample
   always_ff @(posedge clock) begin
      if (reset) begin
         remembered_ff <= '1;
         level_ff      <= '0;
         for (int i = 0; i < bspd_pkg::NUM_BUTTONS; i++) begin
            last_time_ff[i] <= '0;
         end
      end else if (push) begin
         remembered_ff <= remembered_in;
         level_ff      <= level_in;
         for (int i = 0; i < bspd_pkg::NUM_BUTTONS; i++) begin
            last_time_ff[i] <= last_time_in[i];
         end
      end
   end

endmodule

// ===== rtl/core/bspd_queue.sv =====
// Short queue of classified samples between the dimmer front and back ends.
// Depends on bspd_pkg.

module bspd_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  bspd_pkg::entry_type  push_entry,
   output logic                 full,
   input  logic                 pop,
   output logic                 valid,
   output bspd_pkg::entry_type  pop_entry
);

   localparam int PTR_BITS   = $clog2(bspd_pkg::QUEUE_DEPTH);
   localparam int COUNT_BITS = $clog2(bspd_pkg::QUEUE_DEPTH + 1);

   bspd_pkg::entry_type     slot_ff [bspd_pkg::QUEUE_DEPTH];
   logic [PTR_BITS-1:0]     wr_ptr_ff;
   logic [PTR_BITS-1:0]     rd_ptr_ff;
   logic [COUNT_BITS-1:0]   count_ff;
   logic [COUNT_BITS-1:0]   count_in;

   assign full      = count_ff == COUNT_BITS'(bspd_pkg::QUEUE_DEPTH);
   assign valid     = count_ff != '0;
   assign pop_entry = slot_ff[rd_ptr_ff];

   // Track occupancy
   always_comb begin
      count_in = count_ff;
      if (push && !(pop && valid)) begin
         count_in = count_ff + COUNT_BITS'(1);
      end else if (!push && pop && valid) begin
         count_in = count_ff - COUNT_BITS'(1);
      end
   end

   // Advance the pointers
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + PTR_BITS'(1);
         end
         if (pop && valid) begin
            rd_ptr_ff <= rd_ptr_ff + PTR_BITS'(1);
         end
      end
   end

   // Store the entry
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// ===== rtl/core/bspd_back.sv =====
// Back end of the stepped PWM dimmer: maps the level to percent and duty,
// scales the compare value and holds the result register. Depends on bspd_pkg.

module bspd_back (
   input  logic                 clock,
   input  logic                 reset,
   input  bspd_pkg::cfg_type    cfg,
   input  logic                 queue_valid,
   input  bspd_pkg::entry_type  queue_entry,
   output logic                 pop,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output bspd_pkg::rsp_type    rsp_payload
);

   bspd_pkg::back_state_type              state_ff;
   bspd_pkg::back_state_type              state_in;
   bspd_pkg::entry_type                   entry_ff;
   bspd_pkg::entry_type                   entry_in;
   logic [bspd_pkg::PERCENT_BITS-1:0]     mapped_ff;
   logic [bspd_pkg::PERCENT_BITS-1:0]     mapped_in;
   logic [bspd_pkg::DUTY_BITS-1:0]        duty_ff;
   logic [bspd_pkg::DUTY_BITS-1:0]        duty_in;
   logic [bspd_pkg::PRODUCT_BITS-1:0]     product_ff;
   logic [bspd_pkg::PRODUCT_BITS-1:0]     product_in;
   logic [bspd_pkg::COMPARE_BITS-1:0]     quot_ff;
   logic [bspd_pkg::COMPARE_BITS-1:0]     quot_in;
   logic                                  rsp_valid_ff;
   logic                                  rsp_valid_in;
   bspd_pkg::rsp_type                     rsp_ff;
   bspd_pkg::rsp_type                     rsp_in;

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // Sequence one sample: look up, multiply, estimate quotient, correct
   always_comb begin
      logic [bspd_pkg::PRODUCT_BITS+8:0]  scaled;
      logic [bspd_pkg::PRODUCT_BITS:0]    remainder;
      logic                               out_free;
      state_in     = state_ff;
      entry_in     = entry_ff;
      mapped_in    = mapped_ff;
      duty_in      = duty_ff;
      product_in   = product_ff;
      quot_in      = quot_ff;
      rsp_in       = rsp_ff;
      pop          = 1'b0;
      out_free     = !rsp_valid_ff || !rsp_stall;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      scaled       = '0;
      remainder    = '0;
      unique case (state_ff)
         bspd_pkg::BK_IDLE: begin
            if (queue_valid) begin
               pop       = 1'b1;
               entry_in  = queue_entry;
               mapped_in = bspd_pkg::MAP_TABLE[queue_entry.level];
               state_in  = bspd_pkg::BK_MUL;
            end
         end
         bspd_pkg::BK_MUL: begin
            duty_in    = bspd_pkg::DUTY_TABLE[mapped_ff];
            product_in = bspd_pkg::PRODUCT_BITS'(duty_in) *
                         bspd_pkg::PRODUCT_BITS'(cfg.pwm_period);
            state_in   = bspd_pkg::BK_DIV;
         end
         bspd_pkg::BK_DIV: begin
            // p * 257 / 65536 is p / 255 or one less
            scaled   = {9'd0, product_ff} + {1'b0, product_ff, 8'd0};
            quot_in  = scaled[bspd_pkg::COMPARE_BITS+15:16];
            state_in = bspd_pkg::BK_FIX;
         end
         bspd_pkg::BK_FIX: begin
            if (out_free) begin
               remainder = {1'b0, product_ff} - {1'b0, quot_ff, 8'd0} +
                           {9'd0, quot_ff};
               rsp_in.compare_value  = (remainder >= (bspd_pkg::PRODUCT_BITS+1)'
                                        (bspd_pkg::DUTY_FULL))
                                       ? quot_ff + bspd_pkg::COMPARE_BITS'(1) : quot_ff;
               rsp_in.duty           = duty_ff;
               rsp_in.level_percent  = entry_ff.level;
               rsp_in.output_percent = mapped_ff;
               rsp_in.press_mask     = entry_ff.press_mask;
               rsp_in.changed        = entry_ff.press_mask != '0;
               rsp_valid_in          = 1'b1;
               state_in              = bspd_pkg::BK_IDLE;
            end
         end
      endcase
   end

   // Hold control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bspd_pkg::BK_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Hold the working values and the result
   always_ff @(posedge clock) begin
      entry_ff   <= entry_in;
      mapped_ff  <= mapped_in;
      duty_ff    <= duty_in;
      product_ff <= product_in;
      quot_ff    <= quot_in;
      rsp_ff     <= rsp_in;
   end

endmodule

// ===== rtl/core/button_stepped_pwm_dimmer.sv =====
// Top level of the stepped PWM dimmer: configuration registers, front end,
// sample queue and back end. Depends on bspd_pkg and the bspd_* modules.

// Each request transaction is one sample of the buttons with its millisecond
// timestamp and yields exactly one response transaction. The front end does
// the debounce, step sum and clamp of a sample combinationally, registers them
// on the edge of acceptance and parks the sample in a two-entry queue; the
// back-end sequencer then takes one sample at a time through table lookup, duty
// times period, reciprocal estimate of the divide by 255 and correction into the
// output register, and pops the next only after the last is written out; the
// correction waits while a stalled response still holds the output register.
// The request side stalls only when the queue is full. Configuration writes
// take effect at once and belong in idle periods.

module button_stepped_pwm_dimmer (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  bspd_pkg::req_type                   req_payload,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output bspd_pkg::rsp_type                   rsp_payload,
   input  logic                                csr_write_enable,
   input  logic [bspd_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [bspd_pkg::CSR_DATA_BITS-1:0]  csr_write_data
);

   bspd_pkg::cfg_type    cfg_ff;
   logic                 push;
   bspd_pkg::entry_type  push_entry;
   logic                 queue_full;
   logic                 pop;
   logic                 queue_valid;
   bspd_pkg::entry_type  queue_entry;

   assign req_stall = queue_full;

   // Write the configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_ms <= bspd_pkg::DEBOUNCE_BITS'(50);
         cfg_ff.pwm_period  <= bspd_pkg::PERIOD_BITS'(1000);
         cfg_ff.small_step  <= bspd_pkg::STEP_BITS'(1);
         cfg_ff.large_step  <= bspd_pkg::STEP_BITS'(10);
      end else if (csr_write_enable) begin
         unique case (bspd_pkg::csr_index_type'(csr_index))
            bspd_pkg::CSR_DEBOUNCE_MS: begin
               cfg_ff.debounce_ms <= csr_write_data[bspd_pkg::DEBOUNCE_BITS-1:0];
            end
            bspd_pkg::CSR_PWM_PERIOD: begin
               cfg_ff.pwm_period <= csr_write_data[bspd_pkg::PERIOD_BITS-1:0];
            end
            bspd_pkg::CSR_SMALL_STEP: begin
               cfg_ff.small_step <= csr_write_data[bspd_pkg::STEP_BITS-1:0];
            end
            bspd_pkg::CSR_LARGE_STEP: begin
               cfg_ff.large_step <= csr_write_data[bspd_pkg::STEP_BITS-1:0];
            end
         endcase
      end
   end

   bspd_front u_front (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .req_valid   (req_valid),
      .req_payload (req_payload),
      .queue_full  (queue_full),
      .push        (push),
      .push_entry  (push_entry)
   );

   bspd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (queue_full),
      .pop        (pop),
      .valid      (queue_valid),
      .pop_entry  (queue_entry)
   );

   bspd_back u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .queue_valid (queue_valid),
      .queue_entry (queue_entry),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule
